// File: design/rez_pkg.sv
package rez_pkg;

    typedef logic signed [63:0] fx_t;

    localparam fx_t FX_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [62:0]       step_value;
        logic signed [63:0] point_x;
        logic signed [63:0] point_y;
        logic signed [63:0] point_z;
    } rez_item_t;

    typedef struct packed {
        logic signed [63:0] estimate_x;
        logic signed [63:0] estimate_y;
        logic signed [63:0] estimate_z;
        logic signed [63:0] error_x;
        logic signed [63:0] error_y;
        logic signed [63:0] error_z;
        logic               table_full;
    } rez_result_t;

    typedef struct packed {
        logic rot;
        logic push;
        logic load;
    } rez_cell_ctl_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_RATIO,
        UPD_TAB
    } rez_upd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAT,
        S_RAT_WAIT,
        S_COL,
        S_MB1,
        S_DIV,
        S_MC,
        S_MCC,
        S_FIN,
        S_ROT,
        S_PUSH
    } rez_state_t;

    function automatic logic [63:0] fx_mag(input fx_t a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic fx_t fx_clamp(input logic [64:0] v);
        if (v[64] != v[63])
        begin
            return v[64] ? FX_MIN : FX_MAX;
        end
        return v[63:0];
    endfunction

    function automatic fx_t fx_add(input fx_t a, input fx_t b);
        return fx_clamp({a[63], a} + {b[63], b});
    endfunction

    function automatic fx_t fx_sub(input fx_t a, input fx_t b);
        return fx_clamp({a[63], a} - {b[63], b});
    endfunction

    function automatic fx_t fx_pack(input logic neg, input logic [63:0] m, input logic ovf);
        if (!neg)
        begin
            return (ovf || m[63]) ? FX_MAX : m;
        end
        if (ovf || m[63])
        begin
            return FX_MIN;
        end
        return ~m + 64'd1;
    endfunction

endpackage

// File: design/rational_extrapolation_to_zero_core.sv
// rational extrapolation to zero of a DIM-component point sequence, values in signed
// Q31.32. a beat is taken when start is high and busy is low; its result appears on
// result, marked by done high for exactly one cycle, and cannot be held off by the receiver.
// a start beat (or an add to an empty sequence) answers in the cycle after it is taken;
// so does an add against a full tableau (table_full set, estimates zero). any other add
// walks a ring of MAX_N cells, each holding one stored step, one ratio and one tableau
// column entry per component: one ring turn forms the ratios h_old/h with the shared
// divider, then one turn per component runs the column update, which per entry uses
// the shared multiplier three times and the divider once; where a zero denominator
// turns up, the division and the two multiplications after it are skipped. the
// divider sets the pace.
module rational_extrapolation_to_zero_core
    import rez_pkg::*;
#(
    parameter int DIM   = 3,
    parameter int MAX_N = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rez_item_t   item,
    output logic        done,
    output rez_result_t result
);

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int POS_W = $clog2(MAX_N);
    localparam int J_W   = (DIM > 1) ? $clog2(DIM) : 1;

    // control state
    rez_state_t       state_reg, state_next;
    logic [POS_W-1:0] pos_reg;
    logic [J_W-1:0]   j_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             col_phase_reg;
    logic             done_reg, done_next;

    // working values of the column update
    logic [62:0] h_reg;
    fx_t         pt_reg [DIM];
    fx_t         prev_reg;
    fx_t         c_reg;
    fx_t         sum_reg;
    fx_t         corr_reg;
    fx_t         b1_reg;
    fx_t         q_reg;
    fx_t         ratio_hold_reg;
    rez_upd_t    upd_kind_reg;
    fx_t         upd_val_reg;
    fx_t         est_reg [DIM];
    fx_t         err_reg [DIM];
    logic        full_reg;

    // shared arithmetic units
    logic mul_go, mul_done;
    fx_t  mul_a, mul_b, mul_res;
    logic div_go, div_done;
    fx_t  div_a, div_b, div_res;

    // cell ring
    logic                 cell_rot, cell_push, cell_load;
    logic [62:0]          c_step  [MAX_N];
    fx_t                  c_ratio [MAX_N];
    logic [DIM-1:0][63:0] c_tab   [MAX_N];
    fx_t                  wb_ratio;
    logic [DIM-1:0][63:0] wb_tab;
    logic [62:0]          prv0_step;

    fx_t                  all_pt [3];
    fx_t                  pt_in  [DIM];
    logic [DIM-1:0][63:0] ld_tab;
    fx_t                  est_vec [3];
    fx_t                  err_vec [3];

    logic             accept;
    logic             is_new;
    logic             is_full;
    logic             last_pos;
    logic [CNT_W-1:0] pos_ext;
    fx_t              head_tab_j;
    fx_t              b_val;

    assign all_pt[0] = item.point_x;
    assign all_pt[1] = item.point_y;
    assign all_pt[2] = item.point_z;

    for (genvar k = 0; k < DIM; k++)
    begin : g_pt
        assign pt_in[k]  = all_pt[k];
        assign ld_tab[k] = all_pt[k];
    end

    // components at and above DIM read as zero
    for (genvar k = 0; k < 3; k++)
    begin : g_out
        if (k < DIM)
        begin : g_used
            assign est_vec[k] = est_reg[k];
            assign err_vec[k] = err_reg[k];
        end
        else
        begin : g_unused
            assign est_vec[k] = '0;
            assign err_vec[k] = '0;
        end
    end

    always_comb
    begin
        accept     = start && (state_reg == S_IDLE);
        is_new     = (item.cmd == CMD_START) || (cnt_reg == '0);
        is_full    = cnt_reg >= CNT_W'(MAX_N);
        last_pos   = pos_reg == POS_W'(MAX_N - 1);
        pos_ext    = CNT_W'(pos_reg);
        head_tab_j = c_tab[0][j_reg];
        b_val      = fx_sub(mul_res, c_reg);
    end

    // head write-back: the head cell goes round to the tail with at most one field updated
    always_comb
    begin
        wb_ratio = (upd_kind_reg == UPD_RATIO) ? upd_val_reg : c_ratio[0];
        wb_tab   = c_tab[0];
        if (upd_kind_reg == UPD_TAB)
        begin
            wb_tab[j_reg] = upd_val_reg;
        end
        prv0_step = (state_reg == S_IDLE) ? item.step_value : h_reg;
    end

    // next state and unit strobes
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        mul_go     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_go     = 1'b0;
        div_a      = '0;
        div_b      = '0;
        cell_rot   = 1'b0;
        cell_push  = 1'b0;
        cell_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (is_new)
                    begin
                        cell_push = 1'b1;
                        cell_load = 1'b1;
                        done_next = 1'b1;
                    end
                    else if (is_full)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_RAT;
                    end
                end
            end
            S_RAT:
            begin
                if (pos_ext < cnt_reg)
                begin
                    div_go     = 1'b1;
                    div_a      = {1'b0, c_step[0]};
                    div_b      = {1'b0, h_reg};
                    state_next = S_RAT_WAIT;
                end
                else
                begin
                    state_next = S_ROT;
                end
            end
            S_RAT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_ROT;
                end
            end
            S_COL:
            begin
                if (pos_reg != '0 && pos_ext <= cnt_reg)
                begin
                    mul_go     = 1'b1;
                    mul_a      = ratio_hold_reg;
                    mul_b      = prev_reg;
                    state_next = S_MB1;
                end
                else
                begin
                    state_next = S_ROT;
                end
            end
            S_MB1:
            begin
                if (mul_done)
                begin
                    if (b_val == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_go     = 1'b1;
                        div_a      = fx_sub(c_reg, prev_reg);
                        div_b      = b_val;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mul_go     = 1'b1;
                    mul_a      = c_reg;
                    mul_b      = div_res;
                    state_next = S_MC;
                end
            end
            S_MC:
            begin
                if (mul_done)
                begin
                    mul_go     = 1'b1;
                    mul_a      = b1_reg;
                    mul_b      = q_reg;
                    state_next = S_MCC;
                end
            end
            S_MCC:
            begin
                if (mul_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cell_rot = 1'b1;
                if (!last_pos)
                begin
                    state_next = col_phase_reg ? S_COL : S_RAT;
                end
                else if (!col_phase_reg || j_reg != J_W'(DIM - 1))
                begin
                    state_next = S_COL;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cell_push  = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            col_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pos_reg       <= '0;
                        j_reg         <= '0;
                        col_phase_reg <= 1'b0;
                        if (is_new)
                        begin
                            cnt_reg <= CNT_W'(1);
                        end
                    end
                end
                S_ROT:
                begin
                    if (last_pos)
                    begin
                        pos_reg <= '0;
                        if (!col_phase_reg)
                        begin
                            col_phase_reg <= 1'b1;
                            j_reg         <= '0;
                        end
                        else if (j_reg != J_W'(DIM - 1))
                        begin
                            j_reg <= j_reg + J_W'(1);
                        end
                        else
                        begin
                            j_reg         <= '0;
                            col_phase_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
                S_PUSH:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    h_reg        <= item.step_value;
                    upd_kind_reg <= UPD_NONE;
                    full_reg     <= !is_new && is_full;
                    for (int k = 0; k < DIM; k++)
                    begin
                        pt_reg[k]  <= pt_in[k];
                        est_reg[k] <= is_new ? pt_in[k] : '0;
                        err_reg[k] <= is_new ? pt_in[k] : '0;
                    end
                end
            end
            S_RAT:
            begin
                upd_kind_reg <= UPD_NONE;
            end
            S_RAT_WAIT:
            begin
                if (div_done)
                begin
                    upd_kind_reg <= UPD_RATIO;
                    upd_val_reg  <= div_res;
                end
            end
            S_COL:
            begin
                if (pos_reg == '0)
                begin
                    // column head takes the new point
                    prev_reg     <= head_tab_j;
                    c_reg        <= pt_reg[j_reg];
                    sum_reg      <= pt_reg[j_reg];
                    corr_reg     <= '0;
                    upd_kind_reg <= UPD_TAB;
                    upd_val_reg  <= pt_reg[j_reg];
                end
                else
                begin
                    upd_kind_reg <= UPD_NONE;
                end
            end
            S_MB1:
            begin
                if (mul_done)
                begin
                    b1_reg <= mul_res;
                    // zero denominator: previous entry passes on
                    if (b_val == '0)
                    begin
                        corr_reg <= prev_reg;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    q_reg <= div_res;
                end
            end
            S_MC:
            begin
                if (mul_done)
                begin
                    corr_reg <= mul_res;
                end
            end
            S_MCC:
            begin
                if (mul_done)
                begin
                    c_reg <= mul_res;
                end
            end
            S_FIN:
            begin
                upd_kind_reg <= UPD_TAB;
                upd_val_reg  <= corr_reg;
                sum_reg      <= fx_add(sum_reg, corr_reg);
                prev_reg     <= head_tab_j;
            end
            S_ROT:
            begin
                // the head leaving holds the ratio of the next column entry
                ratio_hold_reg <= c_ratio[0];
                if (last_pos && col_phase_reg)
                begin
                    est_reg[j_reg] <= sum_reg;
                    err_reg[j_reg] <= corr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    rez_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    rez_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .res   (div_res)
    );

    for (genvar k = 0; k < MAX_N; k++)
    begin : g_cell
        rez_cell_ctl_t        ctl;
        logic [62:0]          n_step;
        fx_t                  n_ratio;
        logic [DIM-1:0][63:0] n_tab;
        logic [62:0]          p_step;

        assign ctl.rot  = cell_rot;
        assign ctl.push = cell_push;
        assign ctl.load = (k == 0) && cell_load;

        if (k == MAX_N - 1)
        begin : g_tail
            assign n_step  = c_step[0];
            assign n_ratio = wb_ratio;
            assign n_tab   = wb_tab;
        end
        else
        begin : g_mid
            assign n_step  = c_step[k + 1];
            assign n_ratio = c_ratio[k + 1];
            assign n_tab   = c_tab[k + 1];
        end

        if (k == 0)
        begin : g_head
            assign p_step = prv0_step;
        end
        else
        begin : g_rest
            assign p_step = c_step[k - 1];
        end

        rez_cell #(.DIM(DIM)) u_cell
        (
            .clk       (clk),
            .ctl       (ctl),
            .nxt_step  (n_step),
            .nxt_ratio (n_ratio),
            .nxt_tab   (n_tab),
            .prv_step  (p_step),
            .ld_tab    (ld_tab),
            .step      (c_step[k]),
            .ratio     (c_ratio[k]),
            .tab       (c_tab[k])
        );
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        result.estimate_x = est_vec[0];
        result.estimate_y = est_vec[1];
        result.estimate_z = est_vec[2];
        result.error_x    = err_vec[0];
        result.error_y    = err_vec[1];
        result.error_z    = err_vec[2];
        result.table_full = full_reg;
    end

    // stored point count never passes the tableau depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_N))
        else $error("point count beyond tableau depth");

    // the shared units are never launched together
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_go && div_go))
        else $error("multiplier and divider launched together");

    // ring walk counters are parked while idle
    a_idle_park: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (pos_reg == '0 && j_reg == '0 && !col_phase_reg))
        else $error("ring position not parked in idle");

    // a result beat always follows a push or an immediate answer
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_PUSH || $past(accept)))
        else $error("result beat without a finished item");

endmodule

// File: design/rez_mul.sv
module rez_mul
    import rez_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  fx_t  a,
    input  fx_t  b,
    output logic done,
    output fx_t  res
);

    logic        run_reg;
    logic [2:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] ua_reg;
    logic [63:0] ub_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [1:0]  sh_reg;
    logic [127:0] acc_reg;
    fx_t         res_reg;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] shifted;
    logic [128:0] rnd;

    always_comb
    begin
        a_part  = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_part  = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        shifted = {64'd0, prod_reg} << {sh_reg, 5'd0};
        // round half away from zero on the magnitude
        rnd     = {1'b0, acc_reg} + 129'h8000_0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg + 3'd1;
            run_reg  <= (cnt_reg != 3'd5);
            done_reg <= (cnt_reg == 3'd5);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ua_reg  <= fx_mag(a);
            ub_reg  <= fx_mag(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg <= 3'd3)
            begin
                prod_reg <= 64'(a_part) * 64'(b_part);
                sh_reg   <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + shifted;
            end
            if (cnt_reg == 3'd5)
            begin
                res_reg <= fx_pack(neg_reg, rnd[95:32], |rnd[128:96]);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: design/rez_div.sv
module rez_div
    import rez_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  fx_t  a,
    input  fx_t  b,
    output logic done,
    output fx_t  res
);

    localparam int unsigned DIV_STEPS = 96;

    logic        run_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [95:0] num_reg;
    logic [63:0] ub_reg;
    logic [63:0] r_reg;
    logic [63:0] q_reg;
    logic        ovf_reg;
    logic        neg_reg;
    fx_t         res_reg;

    logic [63:0] ua;
    logic [63:0] ub;
    logic [64:0] r2;
    logic        ge;
    logic [64:0] r_diff;
    logic [63:0] q_next;
    logic        ovf_next;

    always_comb
    begin
        ua       = fx_mag(a);
        ub       = fx_mag(b);
        r2       = {r_reg, num_reg[95]};
        ge       = r2 >= {1'b0, ub_reg};
        r_diff   = r2 - {1'b0, ub_reg};
        q_next   = {q_reg[62:0], ge};
        ovf_next = ovf_reg | q_reg[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            // zero dividend or zero divisor finish at once
            run_reg  <= (ua != 64'd0) && (ub != 64'd0);
            done_reg <= (ua == 64'd0) || (ub == 64'd0);
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg + 7'd1;
            run_reg  <= (cnt_reg != 7'(DIV_STEPS - 1));
            done_reg <= (cnt_reg == 7'(DIV_STEPS - 1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= {ua, 32'd0};
            ub_reg  <= ub;
            r_reg   <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= a[63] ^ b[63];
            if (ua == 64'd0)
            begin
                res_reg <= '0;
            end
            else if (ub == 64'd0)
            begin
                res_reg <= a[63] ? FX_MIN : FX_MAX;
            end
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[94:0], 1'b0};
            r_reg   <= ge ? r_diff[63:0] : r2[63:0];
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
            if (cnt_reg == 7'(DIV_STEPS - 1))
            begin
                res_reg <= fx_pack(neg_reg, q_next, ovf_next);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: design/rez_cell.sv
module rez_cell
    import rez_pkg::*;
#(
    parameter int DIM = 3
)
(
    input  logic                  clk,
    input  rez_cell_ctl_t         ctl,
    input  logic [62:0]           nxt_step,
    input  fx_t                   nxt_ratio,
    input  logic [DIM-1:0][63:0]  nxt_tab,
    input  logic [62:0]           prv_step,
    input  logic [DIM-1:0][63:0]  ld_tab,
    output logic [62:0]           step,
    output fx_t                   ratio,
    output logic [DIM-1:0][63:0]  tab
);

    logic [62:0]          step_reg;
    fx_t                  ratio_reg;
    logic [DIM-1:0][63:0] tab_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rot)
        begin
            step_reg  <= nxt_step;
            ratio_reg <= nxt_ratio;
            tab_reg   <= nxt_tab;
        end
        else
        begin
            if (ctl.push)
            begin
                step_reg <= prv_step;
            end
            if (ctl.load)
            begin
                tab_reg <= ld_tab;
            end
        end
    end

    assign step  = step_reg;
    assign ratio = ratio_reg;
    assign tab   = tab_reg;

endmodule
